>>> design/model_file_token_scanner_macros.svh
// Assertion macros shared by the token scanner modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MODEL_FILE_TOKEN_SCANNER_MACROS_SVH
`define MODEL_FILE_TOKEN_SCANNER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MFTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define MFTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/mfts_pkg.sv
// Types, constants and character helpers for the model file token scanner.
// No dependencies; imported by every scanner module.
package mfts_pkg;

  localparam int KEYWORD_MAX_DEF = 8;
  localparam int DEPTH_BITS_DEF  = 16;
  localparam int FIFO_DEPTH      = 4;
  localparam int LEN_W           = 16;

  // token kinds
  localparam logic [3:0] KIND_EOF      = 4'd0;
  localparam logic [3:0] KIND_INT      = 4'd1;
  localparam logic [3:0] KIND_FLOAT    = 4'd2;
  localparam logic [3:0] KIND_KEYWORD  = 4'd3;
  localparam logic [3:0] KIND_STRING   = 4'd4;
  localparam logic [3:0] KIND_PCT_CMT  = 4'd5;
  localparam logic [3:0] KIND_BRK_CMT  = 4'd6;
  localparam logic [3:0] KIND_CMT_EOF  = 4'd7;
  localparam logic [3:0] KIND_STR_NL   = 4'd8;
  localparam logic [3:0] KIND_JUNK     = 4'd9;

  // number flag bits
  localparam logic [5:0] NF_EXP  = 6'h01;
  localparam logic [5:0] NF_DOT  = 6'h02;
  localparam logic [5:0] NF_DIG  = 6'h04;
  localparam logic [5:0] NF_SIGN = 6'h08;
  localparam logic [5:0] NF_BAD  = 6'h10;
  localparam logic [5:0] NF_FLT  = 6'h20;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic             is_end;
    logic [7:0]       tok_byte;
    logic [3:0]       kind;
    logic [LEN_W-1:0] length;
    logic             starts_line;
  } mfts_rec_t;

  // an entry holds the one or two records of one accepted beat
  typedef struct packed {
    logic      two;
    mfts_rec_t rec0;
    mfts_rec_t rec1;
  } mfts_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mfts_fifo_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_num_byte(input logic [7:0] c);
    return is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_UE || c == CH_LE
           || c == CH_DOT;
  endfunction

  function automatic logic [5:0] num_update(input logic [5:0] f_in, input logic [7:0] c);
    logic [5:0] f;
    f = f_in;
    if (c == CH_PLUS || c == CH_MINUS) begin
      if ((f & NF_SIGN) == '0) f = f | NF_BAD;
      f = f & ~NF_SIGN;
    end else if (c == CH_DOT) begin
      if ((f & NF_DOT) != '0) f = f | NF_BAD;
      f = (f | NF_DOT | NF_FLT) & ~NF_SIGN;
    end else if (c == CH_UE || c == CH_LE) begin
      if ((f & NF_EXP) != '0) f = f | NF_BAD;
      f = (f | NF_EXP | NF_DOT | NF_SIGN | NF_FLT) & ~NF_DIG;
    end else begin
      f = (f | NF_DIG) & ~NF_SIGN;
    end
    return f;
  endfunction

  function automatic logic [3:0] num_kind(input logic [5:0] f);
    if ((f & NF_BAD) != '0 || (f & NF_DIG) == '0) return KIND_JUNK;
    return ((f & NF_FLT) != '0) ? KIND_FLOAT : KIND_INT;
  endfunction

  function automatic mfts_rec_t mk_rec(input logic e, input logic [7:0] b,
                                       input logic [3:0] k, input logic [LEN_W-1:0] len,
                                       input logic sl);
    mfts_rec_t r;
    r.is_end      = e;
    r.tok_byte    = b;
    r.kind        = k;
    r.length      = len;
    r.starts_line = sl;
    return r;
  endfunction

endpackage

>>> design/mfts_front.sv
// Scanner front end: accepts text beats, runs the mode machine and builds
// the zero, one or two records each beat produces. Depends on mfts_pkg.
`include "model_file_token_scanner_macros.svh"
module mfts_front #(
  parameter int KEYWORD_MAX = mfts_pkg::KEYWORD_MAX_DEF,
  parameter int DEPTH_BITS  = mfts_pkg::DEPTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_text_byte,
  input  logic                in_end_of_text,
  input  mfts_pkg::mfts_fifo_stat_t fifo_stat,
  output logic                push,
  output mfts_pkg::mfts_entry_t push_entry
);
  import mfts_pkg::*;

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_NUM      = 3'd1;
  localparam logic [2:0] M_STR      = 3'd2;
  localparam logic [2:0] M_KEY      = 3'd3;
  localparam logic [2:0] M_PCT_KEEP = 3'd4;
  localparam logic [2:0] M_BRK_KEEP = 3'd5;
  localparam logic [2:0] M_PCT_SKIP = 3'd6;
  localparam logic [2:0] M_BRK_SKIP = 3'd7;

  logic [2:0]            mode_r, mode_nxt;
  logic [7:0]            prev_r, prev_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [5:0]            nf_r, nf_nxt;
  logic                  fok_r, fok_nxt;
  logic                  tsl_r, tsl_nxt;
  logic                  keep_r;
  logic                  accept;
  logic [1:0]            cnt;
  mfts_rec_t             rec_v [2];

  assign in_ready = !fifo_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0]            b;
    logic                  fin;
    logic                  fin_len0;
    logic [3:0]            fkind;
    logic                  take;
    logic                  idle;
    logic [DEPTH_BITS-1:0] dtmp;
    mode_nxt = mode_r;
    prev_nxt = prev_r;
    depth_nxt = depth_r;
    len_nxt = len_r;
    nf_nxt = nf_r;
    fok_nxt = fok_r;
    tsl_nxt = tsl_r;
    cnt = 2'd0;
    rec_v[0] = '0;
    rec_v[1] = '0;
    b = in_text_byte;
    fin = 1'b0;
    fin_len0 = 1'b0;
    fkind = KIND_EOF;
    take = 1'b0;
    idle = 1'b0;
    dtmp = depth_r;

    if (in_end_of_text) begin
      unique case (mode_r)
        M_NUM:      begin fin = 1'b1; fkind = num_kind(nf_r); end
        M_STR:      begin fin = 1'b1; fkind = KIND_STR_NL; end
        M_KEY: begin
          fin = 1'b1;
          fkind = (len_r <= LEN_W'(KEYWORD_MAX) && fok_r) ? KIND_KEYWORD : KIND_JUNK;
        end
        M_PCT_KEEP: begin fin = 1'b1; fkind = KIND_PCT_CMT; end
        M_BRK_KEEP: begin fin = 1'b1; fkind = KIND_CMT_EOF; end
        M_BRK_SKIP: begin
          if (depth_r != '0) begin
            fin = 1'b1;
            fin_len0 = 1'b1;
            fkind = KIND_CMT_EOF;
          end
        end
        default: ;
      endcase
    end else begin
      prev_nxt = b;
      unique case (mode_r)
        M_NUM: begin
          if (is_num_byte(b)) begin
            nf_nxt = num_update(nf_r, b);
            take = 1'b1;
          end else begin
            fin = 1'b1;
            fkind = num_kind(nf_r);
            idle = 1'b1;
          end
        end
        M_STR: begin
          if (b == CH_QUOTE) begin
            fin = 1'b1;
            fkind = KIND_STRING;
          end else if (b == CH_LF) begin
            fin = 1'b1;
            fkind = KIND_STR_NL;
          end else begin
            take = 1'b1;
          end
        end
        M_KEY: begin
          if (is_space(b)) begin
            fin = 1'b1;
            fkind = (len_r <= LEN_W'(KEYWORD_MAX) && fok_r) ? KIND_KEYWORD : KIND_JUNK;
          end else begin
            take = 1'b1;
          end
        end
        M_PCT_KEEP: begin
          if (b == CH_LF) begin
            fin = 1'b1;
            fkind = KIND_PCT_CMT;
          end else begin
            take = 1'b1;
          end
        end
        M_BRK_KEEP: begin
          if (b == CH_RBRK) begin
            if (depth_r != '0) dtmp = depth_r - 1'b1;
            depth_nxt = dtmp;
            if (dtmp == '0) begin
              fin = 1'b1;
              fkind = KIND_BRK_CMT;
            end else begin
              take = 1'b1;
            end
          end else begin
            if (b == CH_LBRK && depth_r != '1) depth_nxt = depth_r + 1'b1;
            take = 1'b1;
          end
        end
        M_PCT_SKIP: begin
          if (b == CH_LF) mode_nxt = M_IDLE;
        end
        M_BRK_SKIP: begin
          if (depth_r == '0) mode_nxt = M_IDLE;
          else if (b == CH_RBRK) depth_nxt = depth_r - 1'b1;
          else if (b == CH_LBRK && depth_r != '1) depth_nxt = depth_r + 1'b1;
        end
        default: idle = 1'b1;
      endcase
    end

    if (fin) begin
      rec_v[0] = mk_rec(1'b1, 8'h00, fkind, fin_len0 ? '0 : len_r, tsl_r);
      cnt = 2'd1;
      mode_nxt = M_IDLE;
    end

    if (take) begin
      rec_v[0] = mk_rec(1'b0, b, KIND_EOF, '0, 1'b0);
      cnt = 2'd1;
      if (len_r != '1) len_nxt = len_r + 1'b1;
    end

    // first byte seen between tokens
    if (idle && !is_space(b)) begin
      if (b == CH_PCT) begin
        if (keep_r) begin
          mode_nxt = M_PCT_KEEP;
          len_nxt = '0;
          tsl_nxt = (prev_r == CH_LF || prev_r == CH_CR);
        end else begin
          mode_nxt = M_PCT_SKIP;
        end
      end else if (b == CH_LBRK) begin
        if (keep_r) begin
          mode_nxt = M_BRK_KEEP;
          len_nxt = '0;
          tsl_nxt = (prev_r == CH_LF || prev_r == CH_CR);
        end else begin
          mode_nxt = M_BRK_SKIP;
        end
        depth_nxt = DEPTH_BITS'(1);
      end else if (b == CH_QUOTE) begin
        mode_nxt = M_STR;
        len_nxt = '0;
        tsl_nxt = (prev_r == CH_LF || prev_r == CH_CR);
      end else begin
        if (is_digit(b) || b == CH_PLUS || b == CH_MINUS || b == CH_DOT) begin
          mode_nxt = M_NUM;
          nf_nxt = num_update(NF_SIGN, b);
        end else begin
          mode_nxt = M_KEY;
          fok_nxt = is_alpha(b) || b == CH_UNDER;
        end
        len_nxt = LEN_W'(1);
        tsl_nxt = (prev_r == CH_LF || prev_r == CH_CR);
        rec_v[cnt[0]] = mk_rec(1'b0, b, KIND_EOF, '0, 1'b0);
        cnt = cnt + 2'd1;
      end
    end

    if (in_end_of_text) begin
      rec_v[cnt[0]] = mk_rec(1'b1, 8'h00, KIND_EOF, '0, tsl_r);
      cnt = cnt + 2'd1;
      mode_nxt = M_IDLE;
      prev_nxt = CH_SPACE;
      depth_nxt = '0;
      len_nxt = '0;
      nf_nxt = '0;
      fok_nxt = 1'b0;
    end
  end

  assign push = accept && (cnt != 2'd0);
  assign push_entry.two  = cnt[1];
  assign push_entry.rec0 = rec_v[0];
  assign push_entry.rec1 = rec_v[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      prev_r  <= CH_SPACE;
      depth_r <= '0;
      len_r   <= '0;
      nf_r    <= '0;
      fok_r   <= 1'b0;
      tsl_r   <= 1'b0;
      keep_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) keep_r <= cfg_wr_data;
      if (accept) begin
        mode_r  <= mode_nxt;
        prev_r  <= prev_nxt;
        depth_r <= depth_nxt;
        len_r   <= len_nxt;
        nf_r    <= nf_nxt;
        fok_r   <= fok_nxt;
        tsl_r   <= tsl_nxt;
      end
    end
  end

  `MFTS_ASSERT(a_eot_clears,
    (accept && in_end_of_text) |=> (mode_r == M_IDLE && depth_r == '0 && prev_r == CH_SPACE),
    "end marker did not return scanner to idle")
  `MFTS_ASSERT(a_eot_pushes,
    (accept && in_end_of_text) |-> (push && push_entry.rec0.is_end),
    "end marker beat produced no end record")

endmodule

>>> design/mfts_fifo.sv
// Short record queue between scanner front end and output stage.
// Depends on mfts_pkg.
`include "model_file_token_scanner_macros.svh"
module mfts_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  mfts_pkg::mfts_entry_t     push_entry,
  input  logic                      pop,
  output mfts_pkg::mfts_entry_t     pop_entry,
  output mfts_pkg::mfts_fifo_stat_t stat
);
  import mfts_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  mfts_entry_t   mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(FIFO_DEPTH));
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // count is unknown until the first reset edge
  `MFTS_ASSERT_ALWAYS(a_no_overflow, (!rst_n || count_r <= CW'(FIFO_DEPTH)),
    "queue count past depth")
  `MFTS_ASSERT(a_push_not_full, push |-> !stat.full, "push into full queue")

endmodule

>>> design/mfts_back.sv
// Output stage: takes queued entries and hands out their records one beat
// at a time from a holding register. Depends on mfts_pkg.
`include "model_file_token_scanner_macros.svh"
module mfts_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mfts_pkg::mfts_entry_t     pop_entry,
  input  mfts_pkg::mfts_fifo_stat_t fifo_stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_token_end,
  output logic [7:0]                out_token_byte,
  output logic [3:0]                out_token_kind,
  output logic [15:0]               out_token_length,
  output logic                      out_starts_line
);
  import mfts_pkg::*;

  mfts_entry_t cur_r;
  logic        cur_valid_r;
  logic        idx_r;
  logic        load;
  mfts_rec_t   rec;

  // the held entry is finished once its last record is taken
  assign load = !cur_valid_r || (out_ready && (idx_r || !cur_r.two));
  assign pop  = load && !fifo_stat.empty;
  assign rec  = idx_r ? cur_r.rec1 : cur_r.rec0;

  assign out_valid        = cur_valid_r;
  assign out_is_token_end = rec.is_end;
  assign out_token_byte   = rec.tok_byte;
  assign out_token_kind   = rec.kind;
  assign out_token_length = rec.length;
  assign out_starts_line  = rec.starts_line;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else if (load) begin
      cur_valid_r <= !fifo_stat.empty;
      idx_r       <= 1'b0;
    end else if (out_ready) begin
      idx_r <= 1'b1;
    end
  end

  `MFTS_ASSERT(a_second_only_if_two, (cur_valid_r && idx_r) |-> cur_r.two, "second record served from single-record entry")

endmodule

>>> design/model_file_token_scanner.sv
// Top level of the model file token scanner: front end, record queue and
// output stage. Depends on mfts_pkg, mfts_front, mfts_fifo, mfts_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | in_text_byte, in_end_of_text
//   out     | out_valid / out_ready | out_is_token_end, out_token_byte,
//           |                       | out_token_kind, out_token_length,
//           |                       | out_starts_line
//   cfg     | cfg_wr_en             | cfg_wr_data (keep_comments)
//
// One beat is taken per cycle while the 4-entry record queue has room; each
// beat yields zero, one or two records, and the output stage sends one record
// per cycle while out_ready is high, so the two records of a beat go out in turn.
// An input beat's first record passes through the queue write, then the output
// holding register.
// Reset is synchronous, active low, and needs no clearing pass.
// Either side may stall independently; the queue absorbs the difference.
module model_file_token_scanner #(
  parameter int KEYWORD_MAX = mfts_pkg::KEYWORD_MAX_DEF,
  parameter int DEPTH_BITS  = mfts_pkg::DEPTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_token_end,
  output logic [7:0]  out_token_byte,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_length,
  output logic        out_starts_line
);
  import mfts_pkg::*;

  logic            push;
  logic            pop;
  mfts_entry_t     push_entry;
  mfts_entry_t     pop_entry;
  mfts_fifo_stat_t fifo_stat;

  mfts_front #(
    .KEYWORD_MAX (KEYWORD_MAX),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .push_entry     (push_entry)
  );

  mfts_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (fifo_stat)
  );

  mfts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_entry        (pop_entry),
    .fifo_stat        (fifo_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_token_end (out_is_token_end),
    .out_token_byte   (out_token_byte),
    .out_token_kind   (out_token_kind),
    .out_token_length (out_token_length),
    .out_starts_line  (out_starts_line)
  );

endmodule

>>> tb/sv/tb_model_file_token_scanner.sv
// Self-checking testbench for model_file_token_scanner: a directed table, then random token text.
// Records are predicted per accepted beat and checked in order. Needs mfts_pkg and the design.
`timescale 1ns / 100ps

module tb_model_file_token_scanner;
  import mfts_pkg::*;

  localparam int unsigned DEPTH_SAT = (1 << DEPTH_BITS_DEF) - 1;
  localparam mfts_rec_t   NO_REC    = '0;

  typedef enum logic [2:0] {
    SC_IDLE, SC_NUM, SC_STR, SC_KEY, SC_PCT_KEEP, SC_BRK_KEEP, SC_PCT_SKIP, SC_BRK_SKIP
  } scan_mode_t;

  typedef struct packed {
    logic flt;
    logic bad;
    logic sign;
    logic dig;
    logic dot;
    logic expo;
  } num_state_t;

  typedef struct {
    bit         is_cfg;
    logic [7:0] b;
    logic       e;
    int         n_typed;  // -1: records come from the predictor
    mfts_rec_t  t0;
    mfts_rec_t  t1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_token_end;
  logic [7:0]  out_token_byte;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_length;
  logic        out_starts_line;

  // predictor state
  scan_mode_t  sc_mode = SC_IDLE;
  logic [7:0]  sc_prev = CH_SPACE;
  int unsigned sc_depth = 0;
  logic [15:0] sc_len = '0;
  num_state_t  sc_num = '0;
  logic        sc_first_ok = 1'b0;
  logic        sc_tok_sl = 1'b0;
  logic        sc_keep = 1'b0;

  mfts_rec_t   beat_recs[$];
  mfts_rec_t   due_recs[$];
  dir_row_t    directed_rows[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_fed = 0;
  int unsigned gap_odds = 3;
  bit          no_idle = 1'b0;

  model_file_token_scanner u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_token_end (out_is_token_end),
    .out_token_byte   (out_token_byte),
    .out_token_kind   (out_token_kind),
    .out_token_length (out_token_length),
    .out_starts_line  (out_starts_line)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------- character classes ----------------
  function automatic logic char_is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= CH_CR);
  endfunction

  function automatic logic char_is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic char_is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic char_in_number(logic [7:0] c);
    return char_is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_UE || c == CH_LE
           || c == CH_DOT;
  endfunction

  // ---------------- token predictor ----------------
  task automatic put_rec(logic e, logic [7:0] b, logic [3:0] k, logic [15:0] len, logic sl);
    mfts_rec_t r;
    r.is_end      = e;
    r.tok_byte    = b;
    r.kind        = k;
    r.length      = len;
    r.starts_line = sl;
    beat_recs.push_back(r);
  endtask

  task automatic take_char(logic [7:0] b);
    put_rec(1'b0, b, '0, '0, 1'b0);
    if (sc_len != 16'hFFFF) sc_len = sc_len + 16'd1;
  endtask

  task automatic close_token(logic [3:0] k);
    put_rec(1'b1, 8'h00, k, sc_len, sc_tok_sl);
    sc_mode = SC_IDLE;
  endtask

  task automatic open_token(scan_mode_t m);
    sc_mode   = m;
    sc_len    = '0;
    sc_tok_sl = (sc_prev == CH_LF || sc_prev == CH_CR);
  endtask

  task automatic num_char(logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) begin
      if (!sc_num.sign) sc_num.bad = 1'b1;
      sc_num.sign = 1'b0;
    end else if (c == CH_DOT) begin
      if (sc_num.dot) sc_num.bad = 1'b1;
      sc_num.dot  = 1'b1;
      sc_num.flt  = 1'b1;
      sc_num.sign = 1'b0;
    end else if (c == CH_UE || c == CH_LE) begin
      if (sc_num.expo) sc_num.bad = 1'b1;
      sc_num.expo = 1'b1;
      sc_num.dot  = 1'b1;  // no dot allowed after the exponent mark
      sc_num.sign = 1'b1;
      sc_num.flt  = 1'b1;
      sc_num.dig  = 1'b0;
    end else begin
      sc_num.dig  = 1'b1;
      sc_num.sign = 1'b0;
    end
  endtask

  function automatic logic [3:0] num_verdict();
    if (sc_num.bad || !sc_num.dig) return KIND_JUNK;
    return sc_num.flt ? KIND_FLOAT : KIND_INT;
  endfunction

  function automatic logic [3:0] key_verdict();
    return (sc_len <= 16'(KEYWORD_MAX_DEF) && sc_first_ok) ? KIND_KEYWORD : KIND_JUNK;
  endfunction

  task automatic idle_char(logic [7:0] b);
    if (char_is_blank(b)) begin
      // nothing starts
    end else if (b == CH_PCT) begin
      if (sc_keep) open_token(SC_PCT_KEEP);
      else sc_mode = SC_PCT_SKIP;
    end else if (b == CH_LBRK) begin
      if (sc_keep) open_token(SC_BRK_KEEP);
      else sc_mode = SC_BRK_SKIP;
      sc_depth = 1;
    end else if (char_is_digit(b) || b == CH_PLUS || b == CH_MINUS || b == CH_DOT) begin
      open_token(SC_NUM);
      sc_num      = '0;
      sc_num.sign = 1'b1;
      num_char(b);
      take_char(b);
    end else if (b == CH_QUOTE) begin
      open_token(SC_STR);
    end else begin
      open_token(SC_KEY);
      sc_first_ok = char_is_letter(b) || b == CH_UNDER;
      take_char(b);
    end
  endtask

  // records caused by one accepted beat land in beat_recs
  task automatic scan_beat(logic [7:0] b, logic e);
    beat_recs.delete();
    if (e) begin
      case (sc_mode)
        SC_NUM:      close_token(num_verdict());
        SC_STR:      close_token(KIND_STR_NL);
        SC_KEY:      close_token(key_verdict());
        SC_PCT_KEEP: close_token(KIND_PCT_CMT);
        SC_BRK_KEEP: close_token(KIND_CMT_EOF);
        SC_BRK_SKIP: if (sc_depth != 0) put_rec(1'b1, 8'h00, KIND_CMT_EOF, '0, sc_tok_sl);
        default: ;
      endcase
      put_rec(1'b1, 8'h00, KIND_EOF, '0, sc_tok_sl);
      sc_mode     = SC_IDLE;
      sc_prev     = CH_SPACE;
      sc_depth    = 0;
      sc_len      = '0;
      sc_num      = '0;
      sc_first_ok = 1'b0;
    end else begin
      case (sc_mode)
        SC_NUM: begin
          if (char_in_number(b)) begin
            num_char(b);
            take_char(b);
          end else begin
            close_token(num_verdict());
            idle_char(b);
          end
        end
        SC_STR: begin
          if (b == CH_QUOTE) close_token(KIND_STRING);
          else if (b == CH_LF) close_token(KIND_STR_NL);
          else take_char(b);
        end
        SC_KEY: begin
          if (char_is_blank(b)) close_token(key_verdict());
          else take_char(b);
        end
        SC_PCT_KEEP: begin
          if (b == CH_LF) close_token(KIND_PCT_CMT);
          else take_char(b);
        end
        SC_BRK_KEEP: begin
          if (b == CH_RBRK) begin
            if (sc_depth != 0) sc_depth--;
            if (sc_depth == 0) close_token(KIND_BRK_CMT);
            else take_char(b);
          end else begin
            if (b == CH_LBRK && sc_depth != DEPTH_SAT) sc_depth++;
            take_char(b);
          end
        end
        SC_PCT_SKIP: if (b == CH_LF) sc_mode = SC_IDLE;
        SC_BRK_SKIP: begin
          // the byte after the closing bracket is swallowed here
          if (sc_depth == 0) sc_mode = SC_IDLE;
          else if (b == CH_RBRK) sc_depth--;
          else if (b == CH_LBRK && sc_depth != DEPTH_SAT) sc_depth++;
        end
        default: idle_char(b);
      endcase
      sc_prev = b;
    end
  endtask

  // ---------------- drivers ----------------
  task automatic send_beat(logic [7:0] b, logic e);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic feed(logic [7:0] b, logic e);
    send_beat(b, e);
    scan_beat(b, e);
    foreach (beat_recs[j]) due_recs.push_back(beat_recs[j]);
    beats_fed++;
  endtask

  // stop sending, let every due record drain, then cover beats with no record
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (due_recs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    sc_keep = v;
  endtask

  task automatic add_row(bit c, logic [7:0] b, logic e, int n, mfts_rec_t t0, mfts_rec_t t1);
    dir_row_t r;
    r.is_cfg  = c;
    r.b       = b;
    r.e       = e;
    r.n_typed = n;
    r.t0      = t0;
    r.t1      = t1;
    directed_rows.push_back(r);
  endtask

  // ---------------- random text ----------------
  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return 8'h09;
      2:       return CH_LF;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_solid();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_text(logic [7:0] x, logic [7:0] y);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x || c == y);
    return c;
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  task automatic random_token();
    int unsigned pick;
    int unsigned n;
    int unsigned depth;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      if ($urandom_range(0, 4) == 0) begin
        // loose mix of number characters, mostly junk
        repeat ($urandom_range(1, 6)) begin
          n = $urandom_range(0, 14);
          case (n)
            10:      c = CH_PLUS;
            11:      c = CH_MINUS;
            12:      c = CH_UE;
            13:      c = CH_LE;
            14:      c = CH_DOT;
            default: c = 8'h30 + 8'(n);
          endcase
          feed(c, 1'b0);
        end
      end else begin
        if ($urandom_range(0, 2) == 0) feed(rand_sign(), 1'b0);
        if ($urandom_range(0, 5) == 0) begin
          feed(CH_DOT, 1'b0);
          repeat ($urandom_range(1, 3)) feed(rand_digit(), 1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) feed(rand_digit(), 1'b0);
          if ($urandom_range(0, 2) == 0) begin
            feed(CH_DOT, 1'b0);
            repeat ($urandom_range(0, 2)) feed(rand_digit(), 1'b0);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          feed($urandom_range(0, 1) ? CH_UE : CH_LE, 1'b0);
          if ($urandom_range(0, 1)) feed(rand_sign(), 1'b0);
          repeat ($urandom_range(1, 2)) feed(rand_digit(), 1'b0);
        end
      end
      if ($urandom_range(0, 9) < 7) feed(rand_blank(), 1'b0);
    end else if (pick < 40) begin
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 2))
          0:       c = 8'h41 + 8'($urandom_range(0, 25));
          1:       c = 8'h61 + 8'($urandom_range(0, 25));
          default: c = CH_UNDER;
        endcase
      end else begin
        // a byte that opens a keyword but is not a letter or underscore
        do c = rand_solid();
        while (char_is_digit(c) || char_is_letter(c) || c == CH_PLUS || c == CH_MINUS
               || c == CH_DOT || c == CH_QUOTE || c == CH_PCT || c == CH_LBRK
               || c == CH_UNDER);
      end
      feed(c, 1'b0);
      repeat (n - 1) feed(rand_solid(), 1'b0);
      if ($urandom_range(0, 9) < 8) feed(rand_blank(), 1'b0);
    end else if (pick < 52) begin
      feed(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 8)) feed(rand_text(CH_QUOTE, CH_LF), 1'b0);
      feed(($urandom_range(0, 6) == 0) ? CH_LF : CH_QUOTE, 1'b0);
    end else if (pick < 62) begin
      feed(CH_PCT, 1'b0);
      repeat ($urandom_range(0, 8)) feed(rand_text(CH_LF, CH_LF), 1'b0);
      feed(CH_LF, 1'b0);
    end else if (pick < 72) begin
      feed(CH_LBRK, 1'b0);
      depth = 1;
      while (depth != 0) begin
        n = $urandom_range(0, 9);
        if (n == 0 && depth < 3) begin
          feed(CH_LBRK, 1'b0);
          depth++;
        end else if (n < 3) begin
          feed(CH_RBRK, 1'b0);
          depth--;
        end else begin
          feed(rand_text(CH_LBRK, CH_RBRK), 1'b0);
        end
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) feed(rand_blank(), 1'b0);
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 3)) feed(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      feed(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // ---------------- result side ----------------
  initial begin : drain_side
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !no_idle && $urandom_range(0, gap_odds) == 0)
        stall = $urandom_range(1, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : rec_check
    mfts_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_recs.size() == 0) begin
        $error("unexpected record: end=%0b byte=0x%0h kind=%0d len=%0d sl=%0b",
               out_is_token_end, out_token_byte, out_token_kind, out_token_length,
               out_starts_line);
        mismatch_count++;
      end else begin
        want = due_recs.pop_front();
        cmp_field("is_token_end", 16'(want.is_end), 16'(out_is_token_end));
        cmp_field("token_byte", 16'(want.tok_byte), 16'(out_token_byte));
        cmp_field("token_kind", 16'(want.kind), 16'(out_token_kind));
        cmp_field("token_length", want.length, out_token_length);
        cmp_field("starts_line", 16'(want.starts_line), 16'(out_starts_line));
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin : stimulus
    int unsigned goal;
    int unsigned odds_by_phase [5];
    odds_by_phase = '{3, 2, 5, 40, 1};

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // end marker straight out of reset, comments skipped
    add_row(1'b0, 8'hA5, 1'b1, 1, '{1'b1, 8'h00, KIND_EOF, 16'd0, 1'b0}, NO_REC);
    add_row(1'b0, CH_LF, 1'b0, -1, NO_REC, NO_REC);
    // float ended by a letter: end record plus the keyword's first byte
    add_row(1'b0, "9", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "e", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "-", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "5", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "a", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "_", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_SPACE, 1'b0, -1, NO_REC, NO_REC);
    // string with extreme bytes, cut by a newline
    add_row(1'b0, CH_QUOTE, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, 8'hFF, 1'b0, 1, '{1'b0, 8'hFF, 4'd0, 16'd0, 1'b0}, NO_REC);
    add_row(1'b0, 8'h00, 1'b0, 1, '{1'b0, 8'h00, 4'd0, 16'd0, 1'b0}, NO_REC);
    add_row(1'b0, CH_LF, 1'b0, 1, '{1'b1, 8'h00, KIND_STR_NL, 16'd2, 1'b0}, NO_REC);
    // skipped nested bracket comment, byte after it swallowed
    add_row(1'b0, CH_LBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_LBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_RBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_RBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "A", 1'b0, -1, NO_REC, NO_REC);
    // keep turned on inside a skipped comment: it stays skipped
    add_row(1'b0, CH_PCT, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b1, 8'h01, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, "x", 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_LF, 1'b0, -1, NO_REC, NO_REC);
    // kept bracket comment, keep turned off inside it
    add_row(1'b0, CH_LBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_LBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b1, 8'h00, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_RBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_RBRK, 1'b0, -1, NO_REC, NO_REC);
    // bad sign in a number, cut by the end marker
    add_row(1'b0, CH_PLUS, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, CH_PLUS, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, 8'h5A, 1'b1, -1, NO_REC, NO_REC);
    // end marker inside a skipped bracket comment
    add_row(1'b0, CH_LBRK, 1'b0, -1, NO_REC, NO_REC);
    add_row(1'b0, 8'h00, 1'b1, 2, '{1'b1, 8'h00, KIND_CMT_EOF, 16'd0, 1'b0},
            '{1'b1, 8'h00, KIND_EOF, 16'd0, 1'b0});

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_keep(directed_rows[i].b[0]);
      end else if (directed_rows[i].n_typed < 0) begin
        feed(directed_rows[i].b, directed_rows[i].e);
      end else begin
        send_beat(directed_rows[i].b, directed_rows[i].e);
        scan_beat(directed_rows[i].b, directed_rows[i].e);
        due_recs.push_back(directed_rows[i].t0);
        if (directed_rows[i].n_typed > 1) due_recs.push_back(directed_rows[i].t1);
      end
    end

    // random phases; each boundary drains fully before the register write
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_keep(ph % 2 == 0);
      gap_odds = odds_by_phase[ph];
      no_idle  = (ph == 4);
      goal     = beats_fed + 130;
      while (beats_fed < goal) random_token();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
